[sv/opa_pkg.sv]
package opa_pkg;

   localparam int NUM_REGS   = 4;
   localparam int REG_IDX_W  = 2;
   localparam int CSR_IDX_W  = 4;
   localparam int CFG_W      = 40;
   localparam int FRAME_W    = 20;
   localparam int PAGE_SHIFT = 12;
   localparam int ADDR_W     = 32;
   localparam int FUNC_W     = 4;
   localparam int TAG_W      = 8;
   localparam int ID_W       = 7;
   localparam int LEN_W      = 13;
   localparam int STATUS_W   = 3;
   localparam int WIDE_W     = FRAME_W + 1;

   localparam logic [WIDE_W-1:0] FRAME_LIMIT = WIDE_W'(1) << FRAME_W;
   localparam logic [ID_W-1:0]   OWNER_FREE   = 7'd0;
   localparam logic [ID_W-1:0]   OWNER_KERNEL = 7'd1;

   localparam logic [FUNC_W-1:0] FN_ALLOC     = 4'd0;
   localparam logic [FUNC_W-1:0] FN_ALLOC_RUN = 4'd1;
   localparam logic [FUNC_W-1:0] FN_FREE      = 4'd2;
   localparam logic [FUNC_W-1:0] FN_OWNER     = 4'd3;
   localparam logic [FUNC_W-1:0] FN_MARK      = 4'd4;
   localparam logic [FUNC_W-1:0] FN_UNMARK    = 4'd5;
   localparam logic [FUNC_W-1:0] FN_PENDING   = 4'd6;
   localparam logic [FUNC_W-1:0] FN_RECLAIM   = 4'd7;
   localparam logic [FUNC_W-1:0] FN_SWEEP_ID  = 4'd8;
   localparam logic [FUNC_W-1:0] FN_SWEEP_TAG = 4'd9;
   localparam logic [FUNC_W-1:0] FN_COUNT     = 4'd10;
   localparam logic [FUNC_W-1:0] FN_RESERVE   = 4'd11;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_VIOLATION = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_HELD  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NONE      = 3'd4;

   typedef struct packed {
      logic             used;
      logic [TAG_W-1:0] tag;
   } entry_type;

endpackage

[sv/opa_ram.sv]
module opa_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/owned_page_allocator.sv]
// Page allocator with a used bit and owner tag per page, kept in one RAM with a
// registered read that a small sequencer walks one entry at a time. After reset
// the block is busy while it clears the page store. Every transaction first
// walks the region registers, one region after another, and then dispatches.
// Requests refused at dispatch (unknown function, unaligned address on a page
// function other than reserve, zero run length, refused sweep owner) answer
// right there. A single page operation then tries the regions in turn, reads
// the entry and updates it, or answers invalid once every region has been tried
// without one that holds the frame. An allocation reads and checks each page
// examined, steps past each region in turn and writes each granted page. A
// sweep reads and checks each managed page and then finishes. The single RAM
// read port is why the pages are visited one at a time. The result appears on
// the rsp_ ports for exactly one cycle with rsp_valid, the first cycle in which
// busy is low; the receiver cannot stall it, and start may be raised in that cycle.
module owned_page_allocator #(
   parameter int PAGE_SLOTS  = 4096,
   parameter int MAX_REGIONS = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [opa_pkg::FUNC_W-1:0]       req_func,
   input  logic [opa_pkg::ADDR_W-1:0]       req_page_addr,
   input  logic [opa_pkg::TAG_W-1:0]        req_owner_tag,
   input  logic [opa_pkg::LEN_W-1:0]        req_run_length,
   output logic                             rsp_valid,
   output logic [opa_pkg::STATUS_W-1:0]     rsp_status,
   output logic [opa_pkg::ADDR_W-1:0]       rsp_result_addr,
   output logic [opa_pkg::ID_W-1:0]         rsp_owner_id,
   output logic [opa_pkg::LEN_W-1:0]        rsp_page_total,
   output logic                             rsp_pending,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [opa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [opa_pkg::CFG_W-1:0]        csr_data
);

   localparam int SLOT_W  = $clog2(PAGE_SLOTS);
   localparam int CNT_W   = $clog2(PAGE_SLOTS + 1);
   localparam int RUN_W   = (CNT_W > opa_pkg::LEN_W) ? CNT_W : opa_pkg::LEN_W;
   localparam int RCNT_W  = $clog2(MAX_REGIONS + 1);
   localparam int RIDX_W  = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int REXT_W  = RCNT_W + opa_pkg::REG_IDX_W;
   localparam int ENTRY_W = $bits(opa_pkg::entry_type);
   localparam int WW      = opa_pkg::WIDE_W;

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_LAYOUT = 4'd2;
   localparam logic [3:0] S_LOOKUP = 4'd3;
   localparam logic [3:0] S_PG_RD  = 4'd4;
   localparam logic [3:0] S_PG_EV  = 4'd5;
   localparam logic [3:0] S_AL_RD  = 4'd6;
   localparam logic [3:0] S_AL_EV  = 4'd7;
   localparam logic [3:0] S_FILL   = 4'd8;
   localparam logic [3:0] S_SW_RD  = 4'd9;
   localparam logic [3:0] S_SW_EV  = 4'd10;

   logic [3:0]                   state_ff, state_in;
   logic [RCNT_W-1:0]            r_ff, r_in;
   logic [CNT_W-1:0]             i_ff, i_in;
   logic [RUN_W-1:0]             run_ff, run_in;
   logic [CNT_W-1:0]             off_ff, off_in;
   logic [SLOT_W-1:0]            slot_ff, slot_in;
   logic [opa_pkg::LEN_W-1:0]    len_ff, len_in;
   logic [opa_pkg::LEN_W-1:0]    total_ff, total_in;
   logic [opa_pkg::FUNC_W-1:0]   func_ff, func_in;
   logic [opa_pkg::ADDR_W-1:0]   addr_ff, addr_in;
   logic [opa_pkg::TAG_W-1:0]    owner_ff, owner_in;
   logic [opa_pkg::LEN_W-1:0]    runlen_ff, runlen_in;

   logic [opa_pkg::CFG_W-1:0]    region_ff [opa_pkg::NUM_REGS];
   logic [opa_pkg::FRAME_W-1:0]  span_base_ff [MAX_REGIONS];
   logic [CNT_W-1:0]             span_cnt_ff [MAX_REGIONS];
   logic [CNT_W-1:0]             span_off_ff [MAX_REGIONS];
   logic                         span_we;
   logic [CNT_W-1:0]             span_cnt_new;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [opa_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [opa_pkg::ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;
   logic [opa_pkg::ID_W-1:0]     rsp_owner_ff, rsp_owner_in;
   logic [opa_pkg::LEN_W-1:0]    rsp_total_ff, rsp_total_in;
   logic                         rsp_pending_ff, rsp_pending_in;

   logic                         wr_en;
   logic [SLOT_W-1:0]            wr_addr;
   opa_pkg::entry_type           wr_entry;
   logic [SLOT_W-1:0]            rd_addr;
   logic [ENTRY_W-1:0]           rd_data;
   opa_pkg::entry_type           rd_entry;

   logic [REXT_W-1:0]            r_ext;
   logic [RIDX_W-1:0]            cur;
   logic [opa_pkg::CFG_W-1:0]    reg_val;
   logic [WW-1:0]                cnt_raw, lim, room, clip1, clip2;
   logic [opa_pkg::FRAME_W-1:0]  frame;
   logic [WW-1:0]                diff, slot_sum, run_next, start_rel, start_slot, res_frame;
   logic                         in_region, aligned, refuse;
   logic [opa_pkg::ID_W-1:0]     req_id;
   logic [opa_pkg::ID_W-1:0]     rd_id;
   logic                         sweep_hit;

   opa_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(PAGE_SLOTS)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_entry),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rd_entry  = rd_data;
   assign csr_ready = 1'b1;
   assign busy      = (state_ff != S_IDLE);

   assign r_ext   = {{opa_pkg::REG_IDX_W{1'b0}}, r_ff};
   assign cur     = r_ext[RIDX_W-1:0];
   assign reg_val = (r_ext < REXT_W'(opa_pkg::NUM_REGS))
                    ? region_ff[r_ext[opa_pkg::REG_IDX_W-1:0]] : '0;

   // Region clipping: the frame range may not pass the frame limit and the
   // slots may not pass the store size.
   assign cnt_raw = {1'b0, reg_val[opa_pkg::FRAME_W-1:0]};
   assign lim     = opa_pkg::FRAME_LIMIT - {1'b0, reg_val[opa_pkg::CFG_W-1:opa_pkg::FRAME_W]};
   assign room    = WW'(PAGE_SLOTS) - WW'(off_ff);
   assign clip1   = (cnt_raw > lim) ? lim : cnt_raw;
   assign clip2   = (clip1 > room) ? room : clip1;
   assign span_cnt_new = clip2[CNT_W-1:0];

   assign frame     = addr_ff[opa_pkg::ADDR_W-1:opa_pkg::PAGE_SHIFT];
   assign aligned   = (addr_ff[opa_pkg::PAGE_SHIFT-1:0] == '0);
   assign diff      = {1'b0, frame} - {1'b0, span_base_ff[cur]};
   assign in_region = (span_cnt_ff[cur] != '0) && (frame >= span_base_ff[cur])
                      && (diff < WW'(span_cnt_ff[cur]));
   assign slot_sum  = WW'(span_off_ff[cur]) + diff;

   assign req_id    = owner_ff[opa_pkg::ID_W-1:0];
   assign rd_id     = rd_entry.tag[opa_pkg::ID_W-1:0];
   assign run_next  = WW'(run_ff) + WW'(1);
   assign start_rel = WW'(i_ff) + WW'(1) - WW'(len_ff);
   assign start_slot = WW'(span_off_ff[cur]) + start_rel;
   assign res_frame = WW'(span_base_ff[cur]) + start_rel;

   always_comb begin
      refuse = 1'b0;
      case (func_ff)
         opa_pkg::FN_SWEEP_ID:
            refuse = (req_id == opa_pkg::OWNER_FREE) || (req_id == opa_pkg::OWNER_KERNEL);
         opa_pkg::FN_SWEEP_TAG:
            refuse = (owner_ff == {1'b0, opa_pkg::OWNER_FREE})
                     || (owner_ff == {1'b0, opa_pkg::OWNER_KERNEL});
         default:
            refuse = (req_id == opa_pkg::OWNER_FREE);
      endcase
      if (func_ff == opa_pkg::FN_SWEEP_TAG) begin
         sweep_hit = rd_entry.used && (rd_entry.tag == owner_ff);
      end else begin
         sweep_hit = rd_entry.used && (rd_id == req_id);
      end
   end

   always_comb begin
      state_in  = state_ff;
      r_in      = r_ff;
      i_in      = i_ff;
      run_in    = run_ff;
      off_in    = off_ff;
      slot_in   = slot_ff;
      len_in    = len_ff;
      total_in  = total_ff;
      func_in   = func_ff;
      addr_in   = addr_ff;
      owner_in  = owner_ff;
      runlen_in = runlen_ff;
      span_we   = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = slot_ff;
      wr_entry  = '0;
      rd_addr   = slot_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_addr_in    = rsp_addr_ff;
      rsp_owner_in   = rsp_owner_ff;
      rsp_total_in   = rsp_total_ff;
      rsp_pending_in = rsp_pending_ff;

      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = i_ff[SLOT_W-1:0];
            i_in    = i_ff + CNT_W'(1);
            if (i_ff == CNT_W'(PAGE_SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               func_in   = req_func;
               addr_in   = req_page_addr;
               owner_in  = req_owner_tag;
               runlen_in = req_run_length;
               r_in      = '0;
               off_in    = '0;
               state_in  = S_LAYOUT;
            end
         end
         S_LAYOUT: begin
            if (r_ff == RCNT_W'(MAX_REGIONS)) begin
               // The accumulated offset is now the end of the managed slots.
               r_in     = '0;
               i_in     = '0;
               run_in   = '0;
               total_in = '0;
               rsp_valid_in   = 1'b1;
               rsp_status_in  = opa_pkg::ST_OK;
               rsp_addr_in    = '0;
               rsp_owner_in   = '0;
               rsp_total_in   = '0;
               rsp_pending_in = 1'b0;
               state_in       = S_IDLE;
               case (func_ff) inside
                  opa_pkg::FN_ALLOC, opa_pkg::FN_ALLOC_RUN: begin
                     len_in = (func_ff == opa_pkg::FN_ALLOC) ? opa_pkg::LEN_W'(1) : runlen_ff;
                     if ((func_ff == opa_pkg::FN_ALLOC_RUN) && (runlen_ff == '0)) begin
                        rsp_status_in = opa_pkg::ST_NONE;
                     end else begin
                        rsp_valid_in = 1'b0;
                        state_in     = S_AL_RD;
                     end
                  end
                  opa_pkg::FN_FREE, opa_pkg::FN_OWNER, opa_pkg::FN_MARK,
                  opa_pkg::FN_UNMARK, opa_pkg::FN_PENDING, opa_pkg::FN_RECLAIM,
                  opa_pkg::FN_RESERVE: begin
                     if (!aligned && (func_ff != opa_pkg::FN_RESERVE)) begin
                        rsp_status_in = opa_pkg::ST_INVALID;
                     end else begin
                        rsp_valid_in = 1'b0;
                        state_in     = S_LOOKUP;
                     end
                  end
                  opa_pkg::FN_SWEEP_ID, opa_pkg::FN_SWEEP_TAG, opa_pkg::FN_COUNT: begin
                     if (!refuse) begin
                        rsp_valid_in = 1'b0;
                        state_in     = S_SW_RD;
                     end
                  end
                  default: begin
                     rsp_status_in = opa_pkg::ST_INVALID;
                  end
               endcase
            end else begin
               span_we = 1'b1;
               off_in  = off_ff + span_cnt_new;
               r_in    = r_ff + RCNT_W'(1);
            end
         end
         S_LOOKUP: begin
            if (r_ff == RCNT_W'(MAX_REGIONS)) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = opa_pkg::ST_INVALID;
               rsp_addr_in    = '0;
               rsp_owner_in   = '0;
               rsp_total_in   = '0;
               rsp_pending_in = 1'b0;
               state_in       = S_IDLE;
            end else if (in_region) begin
               slot_in  = slot_sum[SLOT_W-1:0];
               state_in = S_PG_RD;
            end else begin
               r_in = r_ff + RCNT_W'(1);
            end
         end
         S_PG_RD: begin
            rd_addr  = slot_ff;
            state_in = S_PG_EV;
         end
         S_PG_EV: begin
            rsp_valid_in   = 1'b1;
            rsp_status_in  = opa_pkg::ST_OK;
            rsp_addr_in    = '0;
            rsp_owner_in   = '0;
            rsp_total_in   = '0;
            rsp_pending_in = 1'b0;
            state_in       = S_IDLE;
            wr_addr        = slot_ff;
            case (func_ff)
               opa_pkg::FN_FREE: begin
                  if (!rd_entry.used) begin
                     rsp_status_in = opa_pkg::ST_INVALID;
                  end else if (rd_id != req_id) begin
                     rsp_status_in = opa_pkg::ST_VIOLATION;
                  end else begin
                     wr_en = 1'b1;
                  end
               end
               opa_pkg::FN_OWNER: begin
                  rsp_owner_in = rd_id;
               end
               opa_pkg::FN_PENDING: begin
                  rsp_pending_in = rd_entry.tag[opa_pkg::TAG_W-1];
               end
               opa_pkg::FN_RESERVE: begin
                  wr_en         = 1'b1;
                  wr_entry.used = 1'b1;
                  wr_entry.tag  = {1'b0, opa_pkg::OWNER_KERNEL};
               end
               default: begin
                  // Mark, unmark and reclaim one need the caller to hold the page.
                  if ((req_id == opa_pkg::OWNER_FREE) || (req_id == opa_pkg::OWNER_KERNEL)
                      || !rd_entry.used || (rd_id != req_id)) begin
                     rsp_status_in = opa_pkg::ST_NOT_HELD;
                  end else begin
                     wr_en = 1'b1;
                     if (func_ff == opa_pkg::FN_MARK) begin
                        wr_entry.used = 1'b1;
                        wr_entry.tag  = {1'b1, rd_id};
                     end else if (func_ff == opa_pkg::FN_UNMARK) begin
                        wr_entry.used = 1'b1;
                        wr_entry.tag  = {1'b0, rd_id};
                     end
                  end
               end
            endcase
         end
         S_AL_RD: begin
            if (r_ff == RCNT_W'(MAX_REGIONS)) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = opa_pkg::ST_NONE;
               rsp_addr_in    = '0;
               rsp_owner_in   = '0;
               rsp_total_in   = '0;
               rsp_pending_in = 1'b0;
               state_in       = S_IDLE;
            end else if (i_ff >= span_cnt_ff[cur]) begin
               r_in   = r_ff + RCNT_W'(1);
               i_in   = '0;
               run_in = '0;
            end else begin
               rd_addr  = SLOT_W'(WW'(span_off_ff[cur]) + WW'(i_ff));
               state_in = S_AL_EV;
            end
         end
         S_AL_EV: begin
            state_in = S_AL_RD;
            i_in     = i_ff + CNT_W'(1);
            if (rd_entry.used) begin
               run_in = '0;
            end else if (run_next == WW'(len_ff)) begin
               slot_in     = start_slot[SLOT_W-1:0];
               rsp_addr_in = {res_frame[opa_pkg::FRAME_W-1:0], {opa_pkg::PAGE_SHIFT{1'b0}}};
               state_in    = S_FILL;
            end else begin
               run_in = run_next[RUN_W-1:0];
            end
         end
         S_FILL: begin
            wr_en         = 1'b1;
            wr_addr       = slot_ff;
            wr_entry.used = 1'b1;
            wr_entry.tag  = {1'b0, req_id};
            slot_in       = slot_ff + SLOT_W'(1);
            len_in        = len_ff - opa_pkg::LEN_W'(1);
            if (len_ff == opa_pkg::LEN_W'(1)) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = opa_pkg::ST_OK;
               rsp_owner_in   = '0;
               rsp_total_in   = '0;
               rsp_pending_in = 1'b0;
               state_in       = S_IDLE;
            end
         end
         S_SW_RD: begin
            if (i_ff >= off_ff) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = opa_pkg::ST_OK;
               rsp_addr_in    = '0;
               rsp_owner_in   = '0;
               rsp_total_in   = total_ff;
               rsp_pending_in = 1'b0;
               state_in       = S_IDLE;
            end else begin
               rd_addr  = i_ff[SLOT_W-1:0];
               state_in = S_SW_EV;
            end
         end
         S_SW_EV: begin
            wr_addr  = i_ff[SLOT_W-1:0];
            i_in     = i_ff + CNT_W'(1);
            state_in = S_SW_RD;
            if (sweep_hit) begin
               total_in = total_ff + opa_pkg::LEN_W'(1);
               wr_en    = (func_ff != opa_pkg::FN_COUNT);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         i_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < opa_pkg::NUM_REGS; k++) begin
            region_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && (csr_index < opa_pkg::CSR_IDX_W'(opa_pkg::NUM_REGS))
             && (32'(csr_index) < 32'(MAX_REGIONS))) begin
            region_ff[csr_index[opa_pkg::REG_IDX_W-1:0]] <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      r_ff      <= r_in;
      run_ff    <= run_in;
      off_ff    <= off_in;
      slot_ff   <= slot_in;
      len_ff    <= len_in;
      total_ff  <= total_in;
      func_ff   <= func_in;
      addr_ff   <= addr_in;
      owner_ff  <= owner_in;
      runlen_ff <= runlen_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_addr_ff    <= rsp_addr_in;
      rsp_owner_ff   <= rsp_owner_in;
      rsp_total_ff   <= rsp_total_in;
      rsp_pending_ff <= rsp_pending_in;
      if (span_we) begin
         span_base_ff[cur] <= reg_val[opa_pkg::CFG_W-1:opa_pkg::FRAME_W];
         span_cnt_ff[cur]  <= span_cnt_new;
         span_off_ff[cur]  <= off_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_result_addr = rsp_addr_ff;
   assign rsp_owner_id    = rsp_owner_ff;
   assign rsp_page_total  = rsp_total_ff;
   assign rsp_pending     = rsp_pending_ff;

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> busy)
      else $error("store clearing pass did not start after reset");

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not make the block busy");

   a_fail_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != opa_pkg::ST_OK)) |-> (rsp_result_addr == '0))
      else $error("failed transaction returned a nonzero address");

endmodule
